FILE: sv/cdate_pkg.sv
// Shared types, codes and calendar functions for the calendar date counter.
// Depends on nothing; used by cdate_ctrl, cdate_dp and calendar_date_counter.
package cdate_pkg;

  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int YearW  = 12;
  localparam int CountW = 16;

  localparam logic [YearW-1:0]  YearMin  = YearW'(1900);
  localparam logic [YearW-1:0]  YearMax  = YearW'(2100);
  localparam logic [YearW-1:0]  YearTop  = YearW'(4095);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);
  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [DayW-1:0]   DayFirst = DayW'(1);
  localparam logic [DayW-1:0]   DayLast  = DayW'(31);
  localparam logic [DayW-1:0]   DayLeap  = DayW'(29);

  // 25 * Inv25 == 1 mod 4096; y is a multiple of 25 iff y * Inv25 mod 4096 <= 4095 / 25
  localparam logic [YearW-1:0] Inv25   = YearW'(3113);
  localparam logic [YearW-1:0] Lim25   = YearW'(4095 / 25);

  typedef enum logic [1:0] {
    KIND_SET     = 2'd0,
    KIND_ADVANCE = 2'd1,
    KIND_POSTFIX = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_BAD_YEAR  = 2'd2,
    ST_BAD_DAY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [MonthW-1:0] set_month;
    logic [DayW-1:0]   set_day;
    logic [YearW-1:0]  set_year;
    logic [CountW-1:0] day_count;
  } in_beat_t;

  typedef struct packed {
    logic [MonthW-1:0] out_month;
    logic [DayW-1:0]   out_day;
    logic [YearW-1:0]  out_year;
    logic [1:0]        status;
    logic              overflow;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic run_step;
  } cmd_t;

  typedef struct packed {
    logic needs_run;
    logic cnt_last;
  } dp_status_t;

  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
  } date_t;

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = y * Inv25;
    div25 = (prod <= Lim25);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m,
                                             input logic [YearW-1:0] y);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                         len = is_leap(y) ? DayLeap : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:      len = DayW'(30);
      default:                      len = DayLast;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/cdate_ctrl.sv
// Controller for the calendar date counter: handshakes, run state, result valid.
// Depends on cdate_pkg; drives cdate_dp through cmd_t and reads dp_status_t.
module cdate_ctrl
  import cdate_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t sts,
  output cmd_t       cmd
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;

  assign in_ready     = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.run_step = (state == S_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept) begin
            if (sts.needs_run) begin
              state     <= S_RUN;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_RUN: begin
          if (sts.cnt_last) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/cdate_dp.sv
// Datapath for the calendar date counter: held date, day stepper, count, result beat.
// Depends on cdate_pkg; commanded by cdate_ctrl.
module cdate_dp
  import cdate_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  in_beat_t   in_data,
  input  cmd_t       cmd,
  output dp_status_t sts,
  output out_beat_t  out_data
);

  date_t             cur;
  date_t             step_date;
  logic              step_sat;
  logic [CountW-1:0] cnt;
  logic              ovf_acc;
  kind_t             kind;
  logic              month_ok;
  logic              year_ok;
  logic              day_ok;
  logic [MonthW-1:0] m_eff;
  logic [DayW-1:0]   len;
  out_beat_t         acc_beat;

  assign kind          = kind_t'(in_data.kind);
  assign sts.needs_run = (kind == KIND_ADVANCE) && (in_data.day_count != '0);
  assign sts.cnt_last  = (cnt == CountW'(1));

  always_comb begin
    m_eff     = ((cur.month >= MonthJan) && (cur.month <= MonthDec)) ? cur.month : MonthJan;
    len       = days_in(m_eff, cur.year);
    step_date = cur;
    step_sat  = 1'b0;
    if (cur.day < len) begin
      step_date.day = cur.day + DayW'(1);
    end else if (m_eff < MonthDec) begin
      step_date.month = m_eff + MonthW'(1);
      step_date.day   = DayFirst;
    end else if (cur.year >= YearTop) begin
      step_date.month = MonthDec;
      step_date.day   = DayLast;
      step_sat        = 1'b1;
    end else begin
      step_date.year  = cur.year + YearW'(1);
      step_date.month = MonthJan;
      step_date.day   = DayFirst;
    end
  end

  assign month_ok = (in_data.set_month >= MonthJan) && (in_data.set_month <= MonthDec);
  assign year_ok  = (in_data.set_year >= YearMin) && (in_data.set_year <= YearMax);
  assign day_ok   = (in_data.set_day >= DayFirst) &&
                    (in_data.set_day <= days_in(in_data.set_month, in_data.set_year));

  always_comb begin
    acc_beat.out_month = cur.month;
    acc_beat.out_day   = cur.day;
    acc_beat.out_year  = cur.year;
    acc_beat.status    = ST_OK;
    acc_beat.overflow  = 1'b0;
    unique case (kind)
      KIND_SET: begin
        if (!month_ok) begin
          acc_beat.status = ST_BAD_MONTH;
        end else begin
          acc_beat.out_month = in_data.set_month;
          if (!year_ok) begin
            acc_beat.status = ST_BAD_YEAR;
          end else begin
            acc_beat.out_year = in_data.set_year;
            if (day_ok) begin
              acc_beat.out_day = in_data.set_day;
            end else begin
              acc_beat.status = ST_BAD_DAY;
            end
          end
        end
      end
      KIND_POSTFIX: acc_beat.overflow = step_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.month <= MonthJan;
      cur.day   <= DayFirst;
      cur.year  <= YearMin;
    end else if (cmd.accept) begin
      unique case (kind)
        KIND_SET: begin
          if (month_ok) begin
            cur.month <= in_data.set_month;
            if (year_ok) begin
              cur.year <= in_data.set_year;
              if (day_ok) begin
                cur.day <= in_data.set_day;
              end
            end
          end
        end
        KIND_POSTFIX: cur <= step_date;
        default: ;
      endcase
    end else if (cmd.run_step) begin
      cur <= step_date;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt      <= in_data.day_count;
      ovf_acc  <= 1'b0;
      out_data <= acc_beat;
    end else if (cmd.run_step) begin
      cnt     <= cnt - CountW'(1);
      ovf_acc <= ovf_acc | step_sat;
      if (sts.cnt_last) begin
        out_data.out_month <= step_date.month;
        out_data.out_day   <= step_date.day;
        out_data.out_year  <= step_date.year;
        out_data.status    <= ST_OK;
        out_data.overflow  <= ovf_acc | step_sat;
      end
    end
  end

endmodule

FILE: sv/calendar_date_counter.sv
// Calendar date counter top level: joins cdate_ctrl and cdate_dp.
// Depends on cdate_pkg, cdate_ctrl, cdate_dp.
//
// Holds a Gregorian date (reset: January 1, 1900) and answers every input beat
// with one result beat. A set beat checks month, year, then day, and reports an
// error code while keeping the fields written before the failing check. A
// postfix beat steps one day and reports the old date. Set, postfix and
// zero-count advance beats are answered on acceptance; an advance by N days
// runs the day stepper once per day after acceptance and reports the new date.
// Past December 31 of 4095 the date holds and the overflow flag is set. One beat
// is in work at a time; the next is taken while the result waits in the output
// register, as soon as that register is being emptied or is empty.
module calendar_date_counter
  import cdate_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  cmd_t       cmd;
  dp_status_t sts;

  cdate_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdate_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
